// ===== design/vrp_pkg.sv =====
// Shared types and constants of the video register port unit.
// Holds the transaction structs, command and state enums, and register constants.
// No dependencies.
package vrp_pkg;

	// Default video address width and fixed sprite memory size
	localparam int VIDEO_ADDR_BITS_DEF = 16;
	localparam int SPRITE_BYTES = 256;
	localparam int SPR_AW = $clog2(SPRITE_BYTES);

	// Depth of the command and result queues
	localparam int QDEPTH = 2;

	// Request types
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_PHASE = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_MASK    = 3'd1;
	localparam logic [2:0] REG_STATUS  = 3'd2;
	localparam logic [2:0] REG_OAMADDR = 3'd3;
	localparam logic [2:0] REG_OAMDATA = 3'd4;
	localparam logic [2:0] REG_SCROLL  = 3'd5;
	localparam logic [2:0] REG_ADDR    = 3'd6;
	localparam logic [2:0] REG_DATA    = 3'd7;

	// Palette backdrop mirrors and the fold distance
	localparam logic [15:0] PAL_MIRROR0 = 16'h3F10;
	localparam logic [15:0] PAL_MIRROR1 = 16'h3F14;
	localparam logic [15:0] PAL_MIRROR2 = 16'h3F18;
	localparam logic [15:0] PAL_MIRROR3 = 16'h3F1C;
	localparam logic [15:0] PAL_FOLD    = 16'h0010;

	// Register bits and values
	localparam int CTRL_INC_BIT  = 2;
	localparam int CTRL_NMI_BIT  = 7;
	localparam int ST_VBLANK_BIT = 7;
	localparam int ST_SPR0_BIT   = 6;
	localparam logic [7:0] CTRL_NT_KEEP  = 8'hFC;
	localparam logic [7:0] STATUS_RESET  = 8'h80;
	localparam logic [7:0] RD_UNREADABLE = 8'hFF;
	localparam int ADDR_STEP_ROW = 32;

	// Classified commands
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ERR_RD,
		OP_STATUS_RD,
		OP_SPR_RD,
		OP_DATA_RD,
		OP_CTRL_WR,
		OP_MASK_WR,
		OP_ERR_WR,
		OP_SPRADDR_WR,
		OP_SPR_WR,
		OP_SCROLL_WR,
		OP_ADDR_WR,
		OP_DATA_WR,
		OP_PHASE
	} op_t;

	// Frame phases
	typedef enum logic [2:0] {
		PH_VBLANK    = 3'd0,
		PH_PRERENDER = 3'd1,
		PH_SPR0_WAIT = 3'd2,
		PH_SPR0_DONE = 3'd3,
		PH_POSTRENDER = 3'd4
	} phase_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_READ
	} back_state_t;

	// Input transaction
	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic       irq_masked;
	} req_t;

	// Result transaction
	typedef struct packed {
		logic [7:0] read_data;
		logic       access_error;
		logic       nmi_request;
		logic [2:0] frame_phase;
	} res_t;

	// Command passed from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       masked;
	} cmd_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic cmd_valid;
		logic res_full;
	} back_stat_t;

	// Back-end handshakes and status
	typedef struct packed {
		logic cmd_pop;
		logic res_push;
		logic clearing;
	} back_ctl_t;

endpackage

// ===== design/video_register_port_and_frame_phases_unit.sv =====
// An accepted transaction passes the front-end stage register, the command queue, the
// back-end sequencer and the result queue; sprite and data reads also wait on the
// registered memory read. Register accesses and phase ends are taken one per cycle while
// the result queue has room; a sprite or data read holds the sequencer's memory port until done.
// Reset: registers take their reset values at once; the video memory is then swept to
// zero one entry per cycle, all 2**VIDEO_ADDR_BITS entries (65536 by default), with full high.
module video_register_port_and_frame_phases_unit #(
	parameter int VIDEO_ADDR_BITS = vrp_pkg::VIDEO_ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  vrp_pkg::req_t item,
	output logic          empty,
	input  logic          pop,
	output vrp_pkg::res_t result
);
	import vrp_pkg::*;

	cmd_t       front_cmd, back_cmd;
	logic       cmd_push, cmd_full, cmd_empty, res_full;
	back_stat_t back_stat;
	back_ctl_t  back_ctl;
	res_t       back_res;

	// Front end: accept and classify
	vrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.hold     (back_ctl.clearing),
		.cmd_push (cmd_push),
		.cmd      (front_cmd),
		.cmd_full (cmd_full)
	);

	// Command queue between front and back
	vrp_fifo #(.item_t(cmd_t)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (front_cmd),
		.pop    (back_ctl.cmd_pop),
		.rdata  (back_cmd),
		.empty  (cmd_empty),
		.full   (cmd_full)
	);

	assign back_stat.cmd_valid = !cmd_empty;
	assign back_stat.res_full  = res_full;

	// Back end: execute
	vrp_back #(.VIDEO_ADDR_BITS(VIDEO_ADDR_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (back_stat),
		.cmd    (back_cmd),
		.ctl    (back_ctl),
		.res    (back_res)
	);

	// Result queue toward the consumer
	vrp_fifo #(.item_t(res_t)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_ctl.res_push),
		.wdata  (back_res),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.full   (res_full)
	);

`ifndef SYNTHESIS
	// No transaction is taken while the video memory is being cleared
	a_hold_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.clearing |-> full)
		else $error("input accepted during memory clear");

	// The back end never pushes a result into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.res_push |-> !res_full)
		else $error("result queue overflow");

	// The back end only pops a command that is there
	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.cmd_pop |-> !cmd_empty)
		else $error("command queue underflow");

	// A popped command yields exactly one result, now or on the next cycle
	a_pop_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.cmd_pop && !back_ctl.res_push |=> back_ctl.res_push)
		else $error("missing result after command");
`endif

endmodule

// ===== design/vrp_fifo.sv =====
// Small first-in first-out queue of any packed item type.
// Depends on vrp_pkg for the queue depth.
module vrp_fifo #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	input  logic  pop,
	output item_t rdata,
	output logic  empty,
	output logic  full
);
	import vrp_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/vrp_front.sv =====
// Front end: accepts request transactions and classifies them into commands.
// Depends on vrp_pkg for the request, command and opcode types.
module vrp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  vrp_pkg::req_t item,
	input  logic          hold,
	output logic          cmd_push,
	output vrp_pkg::cmd_t cmd,
	input  logic          cmd_full
);
	import vrp_pkg::*;

	cmd_t cmd_s1;
	logic valid_s1;
	logic accept;
	op_t  op_dec;

	// Classify by request type and register index
	always_comb begin
		op_dec = OP_NOP;
		unique case (item.req_type)
			REQ_READ: begin
				unique case (item.reg_index)
					REG_STATUS:  op_dec = OP_STATUS_RD;
					REG_OAMDATA: op_dec = OP_SPR_RD;
					REG_DATA:    op_dec = OP_DATA_RD;
					default:     op_dec = OP_ERR_RD;
				endcase
			end
			REQ_WRITE: begin
				unique case (item.reg_index)
					REG_CTRL:    op_dec = OP_CTRL_WR;
					REG_MASK:    op_dec = OP_MASK_WR;
					REG_STATUS:  op_dec = OP_ERR_WR;
					REG_OAMADDR: op_dec = OP_SPRADDR_WR;
					REG_OAMDATA: op_dec = OP_SPR_WR;
					REG_SCROLL:  op_dec = OP_SCROLL_WR;
					REG_ADDR:    op_dec = OP_ADDR_WR;
					default:     op_dec = OP_DATA_WR;
				endcase
			end
			REQ_PHASE: op_dec = OP_PHASE;
			default:   op_dec = OP_NOP;
		endcase
	end

	// Stage register hands over to the command queue
	assign full     = hold || (valid_s1 && cmd_full);
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op     <= op_dec;
			cmd_s1.data   <= item.write_data;
			cmd_s1.masked <= item.irq_masked;
		end
	end

endmodule

// ===== design/vrp_back.sv =====
// Back end: executes commands against the register file, sprite and video memories.
// Depends on vrp_pkg; holds the video memory and runs its clearing pass after reset.
module vrp_back #(
	parameter int VIDEO_ADDR_BITS = vrp_pkg::VIDEO_ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vrp_pkg::back_stat_t stat,
	input  vrp_pkg::cmd_t      cmd,
	output vrp_pkg::back_ctl_t ctl,
	output vrp_pkg::res_t      res
);
	import vrp_pkg::*;

	localparam int VA = VIDEO_ADDR_BITS;
	localparam int VMEM_DEPTH = 1 << VA;

	back_state_t state_q, state_d;
	op_t         op_q, op_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  ctrl_q, ctrl_d, mask_q, mask_d, status_q, status_d;
	logic [7:0]  scroll_h_q, scroll_h_d, scroll_v_q, scroll_v_d;
	logic        scroll_sec_q, scroll_sec_d, addr_sec_q, addr_sec_d;
	logic [7:0]  rbuf_q, rbuf_d;
	logic [SPR_AW-1:0] spr_addr_q, spr_addr_d;
	logic [VA-1:0] vaddr_q, vaddr_d, clr_q, clr_d;
	logic [VA-1:0] vaddr_fold, vaddr_step, addr_inc;

	// Memories and their ports
	logic [7:0]  vmem [VMEM_DEPTH];
	logic [7:0]  vmem_rd_q, vmem_wdata;
	logic [VA-1:0] vmem_addr;
	logic        vmem_re, vmem_we;
	logic [7:0]  spr_mem [SPRITE_BYTES];
	logic [7:0]  spr_rd_q;
	logic [SPRITE_BYTES-1:0] spr_valid_q;
	logic        spr_re, spr_we;

	// Palette backdrop fold and address step
	always_comb begin
		vaddr_fold = vaddr_q;
		if (32'(vaddr_q) == 32'(PAL_MIRROR0) || 32'(vaddr_q) == 32'(PAL_MIRROR1) ||
		    32'(vaddr_q) == 32'(PAL_MIRROR2) || 32'(vaddr_q) == 32'(PAL_MIRROR3)) begin
			vaddr_fold = vaddr_q - VA'(PAL_FOLD);
		end
		addr_inc   = ctrl_q[CTRL_INC_BIT] ? VA'(ADDR_STEP_ROW) : VA'(1);
		vaddr_step = vaddr_q + addr_inc;
	end

	// Sequencer: next state, register updates and result
	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		phase_d      = phase_q;
		ctrl_d       = ctrl_q;
		mask_d       = mask_q;
		status_d     = status_q;
		scroll_h_d   = scroll_h_q;
		scroll_v_d   = scroll_v_q;
		scroll_sec_d = scroll_sec_q;
		addr_sec_d   = addr_sec_q;
		rbuf_d       = rbuf_q;
		spr_addr_d   = spr_addr_q;
		vaddr_d      = vaddr_q;
		clr_d        = clr_q;
		ctl          = '0;
		res          = '0;
		vmem_re      = 1'b0;
		vmem_we      = 1'b0;
		vmem_addr    = vaddr_fold;
		vmem_wdata   = cmd.data;
		spr_re       = 1'b0;
		spr_we       = 1'b0;
		unique case (state_q)
			BS_CLEAR: begin
				ctl.clearing = 1'b1;
				vmem_we      = 1'b1;
				vmem_addr    = clr_q;
				vmem_wdata   = '0;
				if (clr_q == '1) begin
					state_d = BS_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			BS_IDLE: begin
				if (stat.cmd_valid && !stat.res_full) begin
					ctl.cmd_pop  = 1'b1;
					ctl.res_push = 1'b1;
					op_d         = cmd.op;
					unique case (cmd.op)
						OP_ERR_RD: begin
							res.read_data    = RD_UNREADABLE;
							res.access_error = 1'b1;
						end
						OP_ERR_WR: res.access_error = 1'b1;
						OP_STATUS_RD: begin
							res.read_data          = status_q;
							status_d[ST_VBLANK_BIT] = 1'b0;
							scroll_sec_d           = 1'b0;
							addr_sec_d             = 1'b0;
						end
						OP_SPR_RD: begin
							spr_re       = 1'b1;
							ctl.res_push = 1'b0;
							state_d      = BS_READ;
						end
						OP_DATA_RD: begin
							vmem_re      = 1'b1;
							vaddr_d      = vaddr_step;
							ctl.res_push = 1'b0;
							state_d      = BS_READ;
						end
						OP_CTRL_WR: begin
							ctrl_d          = cmd.data;
							res.nmi_request = cmd.data[CTRL_NMI_BIT] &&
							                  status_q[ST_VBLANK_BIT] && !cmd.masked;
						end
						OP_MASK_WR:    mask_d = cmd.data;
						OP_SPRADDR_WR: spr_addr_d = cmd.data;
						OP_SPR_WR: begin
							spr_we     = 1'b1;
							spr_addr_d = spr_addr_q + 1'b1;
						end
						OP_SCROLL_WR: begin
							if (!scroll_sec_q) begin
								scroll_h_d = cmd.data;
							end else begin
								scroll_v_d = cmd.data;
							end
							scroll_sec_d = !scroll_sec_q;
						end
						OP_ADDR_WR: begin
							if (!addr_sec_q) begin
								vaddr_d = VA'({cmd.data, vaddr_q[7:0]});
							end else begin
								vaddr_d = {vaddr_q[VA-1:8], cmd.data};
							end
							addr_sec_d = !addr_sec_q;
						end
						OP_DATA_WR: begin
							vmem_we = 1'b1;
							vaddr_d = vaddr_step;
						end
						OP_PHASE: begin
							unique case (phase_q)
								PH_VBLANK: begin
									phase_d                 = PH_PRERENDER;
									status_d[ST_VBLANK_BIT] = 1'b0;
									status_d[ST_SPR0_BIT]   = 1'b0;
								end
								PH_PRERENDER: phase_d = PH_SPR0_WAIT;
								PH_SPR0_WAIT: begin
									phase_d               = PH_SPR0_DONE;
									status_d[ST_SPR0_BIT] = 1'b1;
								end
								PH_SPR0_DONE: phase_d = PH_POSTRENDER;
								default: begin
									phase_d                 = PH_VBLANK;
									status_d[ST_VBLANK_BIT] = 1'b1;
									scroll_h_d              = '0;
									scroll_v_d              = '0;
									ctrl_d                  = ctrl_q & CTRL_NT_KEEP;
								end
							endcase
							res.nmi_request = ctrl_d[CTRL_NMI_BIT] &&
							                  status_d[ST_VBLANK_BIT] && !cmd.masked;
						end
						default: ;
					endcase
				end
			end
			BS_READ: begin
				// Registered memory data is back; finish the read
				ctl.res_push = 1'b1;
				state_d      = BS_IDLE;
				if (op_q == OP_DATA_RD) begin
					res.read_data = rbuf_q;
					rbuf_d        = vmem_rd_q;
				end else begin
					res.read_data = spr_valid_q[spr_addr_q] ? spr_rd_q : '0;
				end
			end
			default: state_d = BS_IDLE;
		endcase
		res.frame_phase = phase_d;
	end

	// Video memory, one port
	always_ff @(posedge clk) begin
		if (vmem_we) begin
			vmem[vmem_addr] <= vmem_wdata;
		end
		if (vmem_re) begin
			vmem_rd_q <= vmem[vmem_addr];
		end
	end

	// Sprite memory; unwritten entries read as zero through the valid bits
	always_ff @(posedge clk) begin
		if (spr_we) begin
			spr_mem[spr_addr_q] <= cmd.data;
		end
		if (spr_re) begin
			spr_rd_q <= spr_mem[spr_addr_q];
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	// Architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_NOP;
			phase_q      <= PH_VBLANK;
			ctrl_q       <= '0;
			mask_q       <= '0;
			status_q     <= STATUS_RESET;
			scroll_h_q   <= '0;
			scroll_v_q   <= '0;
			scroll_sec_q <= 1'b0;
			addr_sec_q   <= 1'b0;
			rbuf_q       <= '0;
			spr_addr_q   <= '0;
			vaddr_q      <= '0;
			spr_valid_q  <= '0;
		end else begin
			op_q         <= op_d;
			phase_q      <= phase_d;
			ctrl_q       <= ctrl_d;
			mask_q       <= mask_d;
			status_q     <= status_d;
			scroll_h_q   <= scroll_h_d;
			scroll_v_q   <= scroll_v_d;
			scroll_sec_q <= scroll_sec_d;
			addr_sec_q   <= addr_sec_d;
			rbuf_q       <= rbuf_d;
			spr_addr_q   <= spr_addr_d;
			vaddr_q      <= vaddr_d;
			if (spr_we) begin
				spr_valid_q[spr_addr_q] <= 1'b1;
			end
		end
	end

endmodule
